[hw/rtl/nsp_pkg.sv]
package nsp_pkg;

  localparam int unsigned NIB_W       = 4;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned MAX_NIBBLES = 16;
  // A put of MAX_NIBBLES plus one held nibble yields at most eight bytes.
  localparam int unsigned BYTES_MAX   = 8;
  localparam int unsigned NB_W        = 4;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [1:0] {
    OP_PUT     = 2'd0,
    OP_FLUSH   = 2'd1,
    OP_DISCARD = 2'd2
  } op_t;

  // One unit of work for the back end: the bytes already packed, low byte first.
  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic [NB_W-1:0]    nb;
  } job_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic nempty;
    job_t head;
  } qstat_t;

endpackage

[hw/rtl/nsp_front.sv]
module nsp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [1:0]                  op,
  input  logic [nsp_pkg::VALUE_W-1:0] value,
  input  logic [nsp_pkg::CNT_W-1:0]   nibble_count,
  output logic                        push,
  output nsp_pkg::job_t               job
);
  import nsp_pkg::*;

  localparam int unsigned NNIB = MAX_NIBBLES + 1;

  logic [NIB_W-1:0]         held_r, held_nxt;
  logic                     holding_r, holding_nxt;
  logic [CNT_W-1:0]         eff_cnt;
  logic [CNT_W-1:0]         total;
  logic [CNT_W-1:0]         last_idx;
  logic [NNIB*NIB_W-1:0]    comb;
  logic [NIB_W-1:0]         nib_a [NNIB];
  logic [NB_W-1:0]          put_nb;

  assign eff_cnt  = (nibble_count > CNT_W'(MAX_NIBBLES)) ? CNT_W'(MAX_NIBBLES) : nibble_count;
  assign total    = eff_cnt + CNT_W'(holding_r);
  assign last_idx = total - CNT_W'(1);
  assign put_nb   = total[CNT_W-1:1];

  // The held nibble, if any, goes in front of the new ones.
  assign comb = holding_r ? {value, held_r} : {{NIB_W{1'b0}}, value};

  for (genvar g = 0; g < NNIB; g++) begin : g_nib
    assign nib_a[g] = comb[g*NIB_W +: NIB_W];
  end

  always_comb begin
    held_nxt    = held_r;
    holding_nxt = holding_r;
    job.data    = comb[VALUE_W-1:0];
    job.nb      = '0;
    case (op)
      OP_PUT: begin
        job.nb      = put_nb;
        holding_nxt = total[0];
        held_nxt    = total[0] ? nib_a[last_idx] : '0;
      end
      OP_FLUSH: begin
        job.data    = {{(VALUE_W-NIB_W){1'b0}}, held_r};
        job.nb      = NB_W'(holding_r);
        holding_nxt = 1'b0;
        held_nxt    = '0;
      end
      OP_DISCARD: begin
        holding_nxt = 1'b0;
        held_nxt    = '0;
      end
      default: begin
      end
    endcase
  end

  assign push = accept && (job.nb != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      holding_r <= 1'b0;
    end else if (accept) begin
      held_r    <= held_nxt;
      holding_r <= holding_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_held_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !holding_r |-> held_r == '0)
    else $error("held nibble not cleared");
  a_put_nb_bound: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> job.nb <= NB_W'(BYTES_MAX))
    else $error("job byte count too large");
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op == OP_FLUSH || op == OP_DISCARD)) |=> !holding_r)
    else $error("flush or discard left a nibble held");
`endif

endmodule

[hw/rtl/nsp_queue.sv]
module nsp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  nsp_pkg::job_t   push_job,
  input  logic            pop,
  output logic            full,
  output nsp_pkg::qstat_t stat
);
  import nsp_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full        = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.nempty = (cnt_r != '0);
  assign stat.head   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QPTR_W'(1);
      if (pop)  rp_r <= rp_r + QPTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !(push && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.nempty)
    else $error("queue underflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

[hw/rtl/nsp_back.sv]
module nsp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  nsp_pkg::qstat_t            stat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [nsp_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last
);
  import nsp_pkg::*;

  logic [VALUE_W-1:0] data_r;
  logic [NB_W-1:0]    nb_r;
  logic [IDX_W-1:0]   idx_r;
  logic               busy_r;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_last_r;
  logic               adv;
  logic               is_last;

  // A byte moves into the output register whenever that register is free or being taken.
  assign adv     = busy_r && (!out_valid_r || !out_stall);
  assign is_last = ({1'b0, idx_r} == nb_r - NB_W'(1));
  assign pop     = stat.nempty && (!busy_r || (adv && is_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (adv) begin
        idx_r <= idx_r + IDX_W'(1);
        if (is_last) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= stat.head.data;
      nb_r   <= stat.head.nb;
    end
    if (adv) begin
      out_byte_r <= data_r[idx_r*BYTE_W +: BYTE_W];
      out_last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

`ifndef ASSERT_OFF
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ({1'b0, idx_r} < nb_r))
    else $error("byte index beyond job");
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> nb_r != '0)
    else $error("empty job loaded");
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> busy_r && idx_r == '0)
    else $error("job not loaded after pop");
`endif

endmodule

[hw/rtl/nibble_stream_packer_top.sv]
// Nibble stream packer: packs 1 to 16 nibbles per put item into a byte stream, least
// significant nibble first, the earlier nibble of each byte in bits 3..0. At most one
// nibble is carried over between items; flush sends it out as a byte with a zero upper
// half and discard drops it. The front end accepts one item per cycle whenever the
// two-entry job queue has room, packs the bytes at once and tracks the carried nibble;
// the back end sends one byte per cycle while the receiver does not stall, from the head
// job through an output register, with out_last set on the final byte of each item. A
// put of 16 nibbles yields eight bytes; the sustained item rate is then set by the
// one-byte output register. Items that yield no byte (discard, op 3, a flush with
// nothing held, a put of zero nibbles with nothing held, a put that only leaves a nibble
// held) never enter the queue. The first byte of an item passes through the queue
// entry, the back end's job register and the output register before it appears.
module nibble_stream_packer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [nsp_pkg::VALUE_W-1:0] in_value,
  input  logic [nsp_pkg::CNT_W-1:0]   in_nibble_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nsp_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last
);
  import nsp_pkg::*;

  logic   in_accept;
  logic   push;
  logic   pop;
  logic   q_full;
  job_t   job;
  qstat_t stat;

  // The input is held off only while the job queue is full.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  nsp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .op           (in_op),
    .value        (in_value),
    .nibble_count (in_nibble_count),
    .push         (push),
    .job          (job)
  );

  nsp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .full     (q_full),
    .stat     (stat)
  );

  nsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

[test/nibble_stream_packer_checker.sv]
module nibble_stream_packer_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [nsp_pkg::VALUE_W-1:0] in_value,
  input  logic [nsp_pkg::CNT_W-1:0]   in_nibble_count,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [nsp_pkg::BYTE_W-1:0]  out_byte,
  input  logic                        out_last,
  output int                          errors,
  output int                          bytes_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import nsp_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  packed_byte_t         byte_q[$];
  logic [NIB_W-1:0]     carry_nib;
  logic                 carrying;

  initial begin
    errors     = 0;
    bytes_owed = 0;
  end

  // Appends the bytes that one accepted item completes and updates the carried nibble.
  function automatic void pack_item(logic [1:0] op, logic [VALUE_W-1:0] val,
                                    logic [CNT_W-1:0] cnt);
    int unsigned  n_nib;
    int unsigned  i;
    int           first;
    logic [NIB_W-1:0] nib;
    packed_byte_t b;
    first = byte_q.size();
    case (op)
      OP_PUT: begin
        n_nib = (cnt > MAX_NIBBLES) ? MAX_NIBBLES : cnt;
        for (i = 0; i < n_nib; i++) begin
          nib = val[NIB_W*i +: NIB_W];
          if (carrying) begin
            b.data = {nib, carry_nib};
            b.last = 1'b0;
            byte_q.push_back(b);
            carry_nib = '0;
            carrying  = 1'b0;
          end else begin
            carry_nib = nib;
            carrying  = 1'b1;
          end
        end
      end
      OP_FLUSH: begin
        if (carrying) begin
          b.data = {4'h0, carry_nib};
          b.last = 1'b0;
          byte_q.push_back(b);
        end
        carry_nib = '0;
        carrying  = 1'b0;
      end
      OP_DISCARD: begin
        carry_nib = '0;
        carrying  = 1'b0;
      end
      default: ;
    endcase
    if (byte_q.size() > first) byte_q[byte_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    packed_byte_t want;
    if (!rst_n) begin
      byte_q.delete();
      carry_nib = '0;
      carrying  = 1'b0;
    end else begin
      // Results are checked before the new item is packed: no item yields a byte
      // in the cycle it is accepted.
      if (out_valid && !out_stall) begin
        if (byte_q.size() == 0) begin
          $error("unexpected byte %0h with last %0b", out_byte, out_last);
          errors++;
        end else begin
          want = byte_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, out_byte);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) pack_item(in_op, in_value, in_nibble_count);
    end
    bytes_owed <= byte_q.size();
  end

endmodule

[test/tb_nibble_stream_packer_top.sv]
module tb_nibble_stream_packer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nsp_pkg::*;

  // The opcode that the block ignores; it has no name in the package.
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  // Generous bound on the whole run. The slowest correct run (eight bytes per item,
  // each waiting out a heavily stalling receiver) stays far below it.
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         ITEMS_PER_PHASE = 96;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_op = OP_PUT;
  logic [VALUE_W-1:0] in_value = '0;
  logic [CNT_W-1:0]   in_nibble_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;

  int errors;
  int bytes_owed;
  int cycles = 0;
  // Percentage of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  nibble_stream_packer_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_value       (in_value),
    .in_nibble_count(in_nibble_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last)
  );

  // The checker sits beside the block, watches both channels and counts failures.
  nibble_stream_packer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_value       (in_value),
    .in_nibble_count(in_nibble_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .errors         (errors),
    .bytes_owed     (bytes_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random, at the rate that the current phase sets.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: a hung handshake or a result that never arrives ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_nibble_stream_packer_top: FAIL");
      $finish;
    end
  end

  // Presents one item and returns at the edge at which it is accepted. Idle cycles are
  // inserted beforehand at the sender's current rate. When no idle cycle is drawn,
  // valid simply stays high, so it is never lowered and raised in the same step.
  task automatic send_item(input logic [1:0] op, input logic [VALUE_W-1:0] val,
                           input logic [CNT_W-1:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_value        <= val;
    in_nibble_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the sender back until every byte that has been predicted has come out.
  // The count from the checker is registered, so the wait always steps the clock first.
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_owed != 0);
  endtask

  // Random items are mostly puts, with occasional flushes and discards so that the
  // carried nibble is both used and dropped. Counts favour the legal range but also
  // take zero and the saturated range above sixteen. Ignored items are not counted.
  task automatic random_phase(input int n_items);
    int                 n;
    int                 k;
    logic [1:0]         op;
    logic [VALUE_W-1:0] val;
    logic [CNT_W-1:0]   cnt;
    n = 0;
    while (n < n_items) begin
      k = $urandom_range(99);
      if (k < 70)      op = OP_PUT;
      else if (k < 82) op = OP_FLUSH;
      else if (k < 92) op = OP_DISCARD;
      else             op = OP_UNUSED;
      k = $urandom_range(99);
      if (k < 5)       val = '0;
      else if (k < 10) val = '1;
      else             val = {$urandom(), $urandom()};
      k = $urandom_range(99);
      if (k < 6)       cnt = 5'd0;
      else if (k < 14) cnt = CNT_W'($urandom_range(31, 17));
      else if (k < 30) cnt = 5'd16;
      else             cnt = CNT_W'($urandom_range(15, 1));
      send_item(op, val, cnt);
      if (op != OP_UNUSED) n++;
    end
  endtask

  initial begin
    // Reset is held at the start and never asserted again.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First phase: a lightly idling sender against a heavily stalling receiver.
    send_idle_pct  = 20;
    recv_stall_pct = 80;

    // Directed items. Full-width puts of all ones and all zeros give eight whole bytes.
    send_item(OP_PUT, '1, 5'd16);
    send_item(OP_PUT, '0, 5'd16);
    // A single nibble is held, then flushed out with a zero upper half.
    send_item(OP_PUT, 64'h5, 5'd1);
    send_item(OP_FLUSH, '0, 5'd0);
    // Flush and discard with nothing held do nothing.
    send_item(OP_FLUSH, '1, 5'd31);
    send_item(OP_DISCARD, '1, 5'd31);
    // A held nibble is dropped by discard, so the next byte starts afresh.
    send_item(OP_PUT, 64'hA, 5'd1);
    send_item(OP_DISCARD, '0, 5'd0);
    send_item(OP_PUT, 64'hC3, 5'd2);
    // A put of zero nibbles writes nothing.
    send_item(OP_PUT, 64'h21, 5'd0);
    // Counts above sixteen are saturated, the largest one and the first one.
    send_item(OP_PUT, 64'h0123_4567_89AB_CDEF, 5'd31);
    send_item(OP_PUT, 64'hFEDC_BA98_7654_3210, 5'd17);
    // A held nibble in front of sixteen new ones: eight bytes, one nibble left over.
    send_item(OP_PUT, 64'h7, 5'd1);
    send_item(OP_PUT, 64'h0123_4567_89AB_CDEF, 5'd16);
    // The unused opcode leaves the held nibble alone; the flush after it still sends it.
    send_item(OP_UNUSED, '1, 5'd16);
    send_item(OP_FLUSH, '0, 5'd0);
    // Odd counts carry a nibble from one put into the next.
    send_item(OP_PUT, 64'h9_AB, 5'd3);
    send_item(OP_PUT, 64'h1_2345, 5'd5);
    send_item(OP_PUT, 64'hD, 5'd1);
    send_item(OP_FLUSH, '0, 5'd0);
    // Alternating bit patterns across the whole value.
    send_item(OP_PUT, {16{4'hA}}, 5'd16);
    send_item(OP_PUT, {16{4'h5}}, 5'd15);
    send_item(OP_FLUSH, '0, 5'd0);

    // The sender waits here until every byte has been delivered.
    drain();

    random_phase(ITEMS_PER_PHASE);
    drain();

    // Second phase: the roles are swapped.
    send_idle_pct  = 80;
    recv_stall_pct = 20;
    random_phase(ITEMS_PER_PHASE);
    drain();

    // Last phase: neither side idles, so the block runs at its full rate.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_phase(ITEMS_PER_PHASE);
    drain();

    // A short tail catches any stray byte after the last expected one.
    repeat (16) @(posedge clk);

    if (errors == 0) begin
      $display("tb_nibble_stream_packer_top: PASS");
    end else begin
      $display("tb_nibble_stream_packer_top: FAIL");
    end
    $finish;
  end

endmodule

[nibble_stream_packer_top.f]
hw/rtl/nsp_pkg.sv
hw/rtl/nsp_front.sv
hw/rtl/nsp_queue.sv
hw/rtl/nsp_back.sv
hw/rtl/nibble_stream_packer_top.sv
test/nibble_stream_packer_checker.sv
test/tb_nibble_stream_packer_top.sv
